// File: hdl/dsa_pkg.sv
package dsa_pkg;

  localparam int SLOT_COUNT_DEF = 16;

  localparam int ENTRY_W  = 32;
  localparam int SLOTIN_W = 5;
  localparam int STATUS_W = 2;
  localparam int GIVEN_W  = 4;

  localparam int IN_DATA_W  = 136;
  localparam int OUT_DATA_W = 8;

  localparam logic FN_OPEN  = 1'b0;
  localparam logic FN_CLOSE = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_DONE
  } dsa_state_t;

  typedef struct packed {
    logic done;
    logic found;
  } scan_stat_t;

endpackage

// File: hdl/dsa_scan.sv
module dsa_scan #(
  parameter int SLOT_COUNT = dsa_pkg::SLOT_COUNT_DEF,
  parameter int IDX_W      = $clog2(SLOT_COUNT)
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic [IDX_W-1:0]       base,
  input  logic [SLOT_COUNT-1:0]  used,
  output dsa_pkg::scan_stat_t    stat,
  output logic [IDX_W-1:0]       slot
);
  import dsa_pkg::*;

  localparam logic [IDX_W-1:0] LAST = IDX_W'(SLOT_COUNT - 1);

  logic             busy_r, busy_nxt;
  logic [IDX_W-1:0] cursor_r, cursor_nxt;
  logic [IDX_W-1:0] left_r, left_nxt;
  logic [IDX_W-1:0] base_inc, cursor_inc;
  logic             hit;

  // circular successor, one slot tested per cycle
  assign base_inc   = (base == LAST) ? '0 : base + 1'b1;
  assign cursor_inc = (cursor_r == LAST) ? '0 : cursor_r + 1'b1;
  assign hit        = !used[cursor_r];

  always_comb begin
    busy_nxt   = busy_r;
    cursor_nxt = cursor_r;
    left_nxt   = left_r;
    if (start) begin
      busy_nxt   = 1'b1;
      cursor_nxt = base_inc;
      left_nxt   = LAST;
    end else if (busy_r) begin
      if (hit || left_r == IDX_W'(1)) begin
        busy_nxt = 1'b0;
      end else begin
        cursor_nxt = cursor_inc;
        left_nxt   = left_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
    cursor_r <= cursor_nxt;
    left_r   <= left_nxt;
  end

  assign stat.done  = busy_r && (hit || left_r == IDX_W'(1));
  assign stat.found = busy_r && hit;
  assign slot       = cursor_r;

endmodule

// File: hdl/descriptor_slot_allocator.sv
// channel  direction  tdata (low bit up)                         tuser
// in_      slave      entry_context, entry_read, entry_write,     func
//                     entry_close, slot_to_free, pad to 136
// out_     master     status, slot_given, pad to 8                -
//
// Open: the request passes through EXEC, then SCAN, where the single
// next-fit scanner tests n = 1..SLOT_COUNT-1 slots, one slot a cycle, then
// DONE. Close and rejected requests go from EXEC straight to DONE.
// in_tready is high only between requests.
// Reset clears valid bits, hint and full flag at once; payload is not reset.
// A stalled result holds in the output register; the next word may be
// taken meanwhile and waits in the last step until the register frees.
module descriptor_slot_allocator #(
  parameter int SLOT_COUNT = dsa_pkg::SLOT_COUNT_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // entry_context, entry_read, entry_write, entry_close, slot_to_free
  input  logic [dsa_pkg::IN_DATA_W-1:0] in_tdata,
  // func
  input  logic                          in_tuser,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // status, slot_given
  output logic [dsa_pkg::OUT_DATA_W-1:0] out_tdata
);
  import dsa_pkg::*;

  localparam int IDX_W = $clog2(SLOT_COUNT);

  dsa_state_t state_r, state_nxt;

  logic                  func_r;
  logic [4*ENTRY_W-1:0]  words_r;
  logic [SLOTIN_W-1:0]   slot_in_r;

  logic [4*ENTRY_W-1:0]  payload_mem [SLOT_COUNT];
  logic [SLOT_COUNT-1:0] used_r, used_nxt;
  logic [IDX_W-1:0]      hint_r, hint_nxt;
  logic                  full_r, full_nxt;

  logic [STATUS_W-1:0]   res_status_r, res_status_nxt;
  logic [GIVEN_W-1:0]    res_given_r, res_given_nxt;
  logic                  out_valid_r;
  logic [STATUS_W-1:0]   out_status_r;
  logic [GIVEN_W-1:0]    out_given_r;

  logic                  in_acc, out_free, scan_start, mem_we;
  logic                  close_bad;
  logic [IDX_W-1:0]      close_idx;
  scan_stat_t            scan_stat;
  logic [IDX_W-1:0]      scan_slot;

  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;
  assign close_bad = int'(slot_in_r) >= SLOT_COUNT;
  assign close_idx = IDX_W'(slot_in_r);

  dsa_scan #(
    .SLOT_COUNT(SLOT_COUNT),
    .IDX_W     (IDX_W)
  ) u_scan (
    .clk  (clk),
    .rst_n(rst_n),
    .start(scan_start),
    .base (hint_r),
    .used (used_r),
    .stat (scan_stat),
    .slot (scan_slot)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        if (func_r == FN_OPEN && !full_r) state_nxt = S_SCAN;
        else                              state_nxt = S_DONE;
      end
      S_SCAN: begin
        if (scan_stat.done) state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_tready      = (state_r == S_IDLE);
    scan_start     = 1'b0;
    mem_we         = 1'b0;
    used_nxt       = used_r;
    hint_nxt       = hint_r;
    full_nxt       = full_r;
    res_status_nxt = res_status_r;
    res_given_nxt  = res_given_r;
    unique case (state_r)
      S_EXEC: begin
        res_status_nxt = ST_OK;
        res_given_nxt  = '0;
        if (func_r == FN_OPEN) begin
          if (full_r) begin
            res_status_nxt = ST_FULL;
          end else begin
            mem_we           = 1'b1;
            scan_start       = 1'b1;
            used_nxt[hint_r] = 1'b1;
            res_given_nxt    = GIVEN_W'(hint_r);
          end
        end else if (close_bad) begin
          res_status_nxt = ST_RANGE;
        end else begin
          used_nxt[close_idx] = 1'b0;
          if (close_idx < hint_r || full_r) hint_nxt = close_idx;
          full_nxt = 1'b0;
        end
      end
      S_SCAN: begin
        if (scan_stat.done) begin
          if (scan_stat.found) hint_nxt = scan_slot;
          else                 full_nxt = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      used_r      <= '0;
      hint_r      <= '0;
      full_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      used_r  <= used_nxt;
      hint_r  <= hint_nxt;
      full_r  <= full_nxt;
      if (state_r == S_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
    if (in_acc) begin
      func_r    <= in_tuser;
      words_r   <= in_tdata[4*ENTRY_W-1:0];
      slot_in_r <= in_tdata[4*ENTRY_W +: SLOTIN_W];
    end
    res_status_r <= res_status_nxt;
    res_given_r  <= res_given_nxt;
    if (state_r == S_DONE && out_free) begin
      out_status_r <= res_status_r;
      out_given_r  <= res_given_r;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      payload_mem[hint_r] <= words_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DATA_W - STATUS_W - GIVEN_W){1'b0}}, out_given_r, out_status_r};

endmodule

// File: hdl/dsa_checker.sv
module dsa_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_tvalid,
  input logic                           in_tready,
  input logic                           out_tvalid,
  input logic                           out_tready,
  input logic [dsa_pkg::OUT_DATA_W-1:0] out_tdata
);
  import dsa_pkg::*;

  logic [STATUS_W-1:0] st;
  logic [GIVEN_W-1:0]  given;

  assign st    = out_tdata[STATUS_W-1:0];
  assign given = out_tdata[STATUS_W +: GIVEN_W];

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result word changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("request taken while previous one in progress");

  a_fail_no_slot: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && st != ST_OK |-> given == '0)
    else $error("slot reported on failed request");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> st == ST_OK || st == ST_FULL || st == ST_RANGE)
    else $error("undefined status code");

endmodule

bind descriptor_slot_allocator dsa_checker u_dsa_checker (.*);
